FILE: src/tlcrk_pkg.sv
`default_nettype none
package tlcrk_pkg;
   localparam int MAX_COUNT = 15;
   localparam int CW = 4;
   localparam int ROW_LEN = MAX_COUNT + 2;
   localparam int TAB_DEPTH = (MAX_COUNT + 1) * ROW_LEN;
   localparam int AW = $clog2(TAB_DEPTH);
   localparam int OW = $clog2(ROW_LEN);
   localparam int VW = 17;

   localparam logic [1:0] CMD_BUILD = 2'd0;
   localparam logic [1:0] CMD_RANK = 2'd1;
   localparam logic [1:0] CMD_UNRANK = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;

   localparam logic [1:0] REG_ANC_FIRST = 2'd0;
   localparam logic [1:0] REG_DER_FIRST = 2'd1;
   localparam logic [1:0] REG_ANC_SECOND = 2'd2;
   localparam logic [1:0] REG_DER_SECOND = 2'd3;

   localparam logic [1:0] TB_INNER = 2'd0;
   localparam logic [1:0] TB_MIDDLE = 2'd1;
   localparam logic [1:0] TB_OUTER = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  pair_anc_anc;
      logic [3:0]  pair_anc_der;
      logic [3:0]  pair_der_anc;
      logic [3:0]  pair_der_der;
      logic [15:0] position_in;
   } req_type;

   typedef struct packed {
      logic [15:0] position_out;
      logic [3:0]  out_anc_anc;
      logic [3:0]  out_anc_der;
      logic [3:0]  out_der_anc;
      logic [3:0]  out_der_der;
      logic [3:0]  only_first_anc;
      logic [3:0]  only_first_der;
      logic [3:0]  only_second_anc;
      logic [3:0]  only_second_der;
      logic [16:0] total_configs;
      logic [1:0]  status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic        load;      // load idx from in_value
      logic        rd;        // issue table read
      logic [1:0]  tab;       // which table
      logic [CW-1:0] row;
      logic [OW-1:0] col;
      logic        acc;       // add read data into running sum
      logic        wr;        // write running sum into table
      logic        clr_sum;
      logic        sub;       // idx -= read data
   } ctl_type;

   typedef struct packed {
      logic [VW-1:0] rdata;
      logic [VW-1:0] idx;
      logic [VW-1:0] sum;
   } sts_type;

   function automatic logic [CW-1:0] lesser(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return (x < y) ? x : y;
   endfunction
endpackage
`default_nettype wire

FILE: src/tlcrk_datapath.sv
`default_nettype none
module tlcrk_datapath (
   input  wire logic              clock,
   input  wire tlcrk_pkg::ctl_type ctl,
   input  wire logic [16:0]       in_value,
   input  wire logic [16:0]       add_value,
   output tlcrk_pkg::sts_type     sts
);
   import tlcrk_pkg::*;

   logic [VW-1:0] inner_mem [TAB_DEPTH];
   logic [VW-1:0] middle_mem [TAB_DEPTH];
   logic [VW-1:0] outer_mem [ROW_LEN];
   logic [VW-1:0] rdata_ff;
   logic [VW-1:0] sum_ff, sum_in;
   logic [VW-1:0] idx_ff, idx_in;
   logic [AW-1:0] addr;

   assign addr = AW'(ctl.row * ROW_LEN) + AW'(ctl.col);

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         unique case (ctl.tab)
            TB_INNER: inner_mem[addr] <= sum_ff;
            TB_MIDDLE: middle_mem[addr] <= sum_ff;
            default: outer_mem[ctl.col] <= sum_ff;
         endcase
      end
      if (ctl.rd) begin
         unique case (ctl.tab)
            TB_INNER: rdata_ff <= inner_mem[addr];
            TB_MIDDLE: rdata_ff <= middle_mem[addr];
            default: rdata_ff <= outer_mem[ctl.col];
         endcase
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clr_sum) sum_in = '0;
      else if (ctl.acc) sum_in = sum_ff + rdata_ff;
      else if (ctl.wr && ctl.tab == TB_INNER) sum_in = sum_ff + add_value;
      idx_in = idx_ff;
      if (ctl.load) idx_in = in_value;
      else if (ctl.sub) idx_in = idx_ff - rdata_ff;
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      idx_ff <= idx_in;
   end

   assign sts.rdata = rdata_ff;
   assign sts.idx = idx_ff;
   assign sts.sum = sum_ff;
endmodule
`default_nettype wire

FILE: src/tlcrk_ctrl.sv
`default_nettype none
module tlcrk_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire tlcrk_pkg::req_type req_data,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [3:0]         csr_data,
   output tlcrk_pkg::ctl_type      ctl,
   output logic [16:0]             in_value,
   output logic [16:0]             add_value,
   input  wire tlcrk_pkg::sts_type sts,
   output logic                    rsp_valid,
   output tlcrk_pkg::rsp_type      rsp_data
);
   import tlcrk_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INNER = 4'd1;   // write inner entries
   localparam logic [3:0] S_MID_RD = 4'd2;  // write middle entries
   localparam logic [3:0] S_MID_AC = 4'd3;
   localparam logic [3:0] S_OUT_RD = 4'd4;
   localparam logic [3:0] S_OUT_AC = 4'd5;
   localparam logic [3:0] S_RANK_RD = 4'd6;
   localparam logic [3:0] S_RANK_AC = 4'd7;
   localparam logic [3:0] S_WALK_RD = 4'd8;
   localparam logic [3:0] S_WALK_CMP = 4'd9;
   localparam logic [3:0] S_SUB_RD = 4'd10;
   localparam logic [3:0] S_SUB = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [3:0] marg_ff [4];
   logic ready_ff, ready_in;
   logic [16:0] total_ff, total_in;
   req_type item_ff, item_in;
   logic [CW:0] i_ff, i_in;      // outer loop counter
   logic [CW:0] j_ff, j_in;      // inner loop counter
   logic [1:0] lvl_ff, lvl_in;   // 0 aa, 1 ad, 2 da; rank step
   logic [3:0] aa_ff, aa_in, ad_ff, ad_in, da_ff, da_in;
   logic [1:0] st_ff, st_in;
   logic        v_ff, v_in;
   rsp_type     r_ff, r_in;

   logic [3:0] af, df, as_, ds;
   logic [3:0] n_ad, n_da, n_aa, lim, cur;
   logic [3:0] i4, j4;
   logic rank_bad;
   logic [3:0] dd4;

   assign af = marg_ff[REG_ANC_FIRST];
   assign df = marg_ff[REG_DER_FIRST];
   assign as_ = marg_ff[REG_ANC_SECOND];
   assign ds = marg_ff[REG_DER_SECOND];
   assign n_ad = lesser(af, ds);
   assign n_da = lesser(as_, df);
   assign n_aa = lesser(af, as_);
   assign i4 = i_ff[CW-1:0];
   assign j4 = j_ff[CW-1:0];
   assign busy = (state_ff != S_IDLE);
   assign dd4 = sts.idx[3:0];

   always_comb begin
      unique case (lvl_ff)
         2'd0: begin lim = n_aa; cur = aa_ff; end
         2'd1: begin lim = lesser(af - aa_ff, ds); cur = ad_ff; end
         default: begin lim = lesser(as_ - aa_ff, df); cur = da_ff; end
      endcase
   end

   assign rank_bad = (req_data.pair_anc_anc > n_aa)
      || (req_data.pair_anc_der > lesser(af - req_data.pair_anc_anc, ds))
      || (req_data.pair_der_anc > lesser(as_ - req_data.pair_anc_anc, df))
      || (req_data.pair_der_der > lesser(df - req_data.pair_der_anc,
                                         ds - req_data.pair_anc_der));

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      total_in = total_ff;
      item_in = item_ff;
      i_in = i_ff;
      j_in = j_ff;
      lvl_in = lvl_ff;
      aa_in = aa_ff;
      ad_in = ad_ff;
      da_in = da_ff;
      st_in = st_ff;
      v_in = 1'b0;
      r_in = r_ff;
      ctl = '0;
      in_value = {1'b0, req_data.position_in};
      add_value = 17'(lesser(df - j4, ds - i4)) + 17'd1;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in = req_data;
               ctl.load = 1'b1;
               ctl.clr_sum = 1'b1;
               i_in = '0;
               j_in = '0;
               lvl_in = '0;
               aa_in = '0;
               ad_in = '0;
               da_in = '0;
               r_in = '0;
               r_in.total_configs = ready_ff ? total_ff : '0;
               unique case (req_data.command) inside
                  CMD_BUILD: state_in = S_INNER;
                  CMD_RANK, CMD_UNRANK: begin
                     if (!ready_ff) begin
                        r_in.total_configs = '0;
                        r_in.status = ST_NOT_BUILT;
                        v_in = 1'b1;
                        state_in = S_DONE;
                     end else if (req_data.command == CMD_RANK) begin
                        if (rank_bad) begin
                           r_in.status = ST_RANGE;
                           v_in = 1'b1;
                           state_in = S_DONE;
                        end else begin
                           state_in = S_RANK_RD;
                        end
                     end else if ({1'b0, req_data.position_in} >= total_ff) begin
                        r_in.status = ST_RANGE;
                        v_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_WALK_RD;
                     end
                  end
                  default: begin
                     r_in.status = ST_RANGE;
                     v_in = 1'b1;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // inner[i][j] = running sum, j walks 0..n_da+1
         S_INNER: begin
            ctl.wr = 1'b1;
            ctl.tab = TB_INNER;
            ctl.row = i4;
            ctl.col = OW'(j_ff);
            if (j_ff == {1'b0, n_da} + 1'b1) begin
               ctl.wr = 1'b1;
               add_value = '0;
               j_in = '0;
               if (i4 == n_ad) begin
                  i_in = '0;
                  state_in = S_MID_RD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
               ctl.clr_sum = 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         // middle[i][j] = sum, then sum += inner[j][col]
         S_MID_RD: begin
            ctl.wr = 1'b1;
            ctl.tab = TB_MIDDLE;
            ctl.row = i4;
            ctl.col = OW'(j_ff);
            if (j_ff == {1'b0, n_ad} + 1'b1) begin
               ctl.clr_sum = 1'b1;
               j_in = '0;
               if (i4 == n_aa) begin
                  i_in = '0;
                  state_in = S_OUT_RD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               state_in = S_MID_AC;
            end
         end
         S_MID_AC: begin
            ctl.rd = 1'b1;
            ctl.tab = TB_INNER;
            ctl.row = j4;
            ctl.col = OW'(lesser(as_ - i4, df)) + OW'(1);
            state_in = S_OUT_AC;
            lvl_in = 2'd1;
         end
         S_OUT_RD: begin
            if (i_ff == {1'b0, n_aa} + 1'b1) begin
               ctl.wr = 1'b1;
               ctl.tab = TB_OUTER;
               ctl.col = OW'(i_ff);
               ready_in = 1'b1;
               total_in = sts.sum;
               r_in.total_configs = sts.sum;
               v_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ctl.rd = 1'b1;
               ctl.tab = TB_MIDDLE;
               ctl.row = i4;
               ctl.col = OW'(lesser(af - i4, ds)) + OW'(1);
               lvl_in = 2'd0;
               state_in = S_OUT_AC;
            end
         end
         S_OUT_AC: begin
            ctl.acc = 1'b1;
            if (lvl_ff == 2'd1) begin
               j_in = j_ff + 1'b1;
               state_in = S_MID_RD;
            end else begin
               ctl.wr = 1'b1;
               ctl.tab = TB_OUTER;
               ctl.col = OW'(i_ff);
               i_in = i_ff + 1'b1;
               state_in = S_OUT_RD;
            end
         end
         // rank: sum outer, middle, inner entries plus pair_der_der
         S_RANK_RD: begin
            ctl.rd = 1'b1;
            unique case (lvl_ff)
               2'd0: begin
                  ctl.tab = TB_OUTER;
                  ctl.col = OW'(item_ff.pair_anc_anc);
               end
               2'd1: begin
                  ctl.tab = TB_MIDDLE;
                  ctl.row = item_ff.pair_anc_anc;
                  ctl.col = OW'(item_ff.pair_anc_der);
               end
               default: begin
                  ctl.tab = TB_INNER;
                  ctl.row = item_ff.pair_anc_der;
                  ctl.col = OW'(item_ff.pair_der_anc);
               end
            endcase
            state_in = S_RANK_AC;
         end
         S_RANK_AC: begin
            ctl.acc = 1'b1;
            if (lvl_ff == 2'd2) begin
               r_in.position_out = 16'(sts.sum + sts.rdata + 17'(item_ff.pair_der_der));
               v_in = 1'b1;
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
               state_in = S_RANK_RD;
            end
         end
         // unrank: read entry cur+1 of current level
         S_WALK_RD: begin
            if (cur >= lim) begin
               state_in = S_SUB_RD;
            end else begin
               ctl.rd = 1'b1;
               unique case (lvl_ff)
                  2'd0: begin
                     ctl.tab = TB_OUTER;
                     ctl.col = OW'(cur) + OW'(1);
                  end
                  2'd1: begin
                     ctl.tab = TB_MIDDLE;
                     ctl.row = aa_ff;
                     ctl.col = OW'(cur) + OW'(1);
                  end
                  default: begin
                     ctl.tab = TB_INNER;
                     ctl.row = ad_ff;
                     ctl.col = OW'(cur) + OW'(1);
                  end
               endcase
               state_in = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            if (sts.idx >= sts.rdata) begin
               unique case (lvl_ff)
                  2'd0: aa_in = aa_ff + 1'b1;
                  2'd1: ad_in = ad_ff + 1'b1;
                  default: da_in = da_ff + 1'b1;
               endcase
               state_in = S_WALK_RD;
            end else begin
               state_in = S_SUB_RD;
            end
         end
         S_SUB_RD: begin
            ctl.rd = 1'b1;
            unique case (lvl_ff)
               2'd0: begin
                  ctl.tab = TB_OUTER;
                  ctl.col = OW'(aa_ff);
               end
               2'd1: begin
                  ctl.tab = TB_MIDDLE;
                  ctl.row = aa_ff;
                  ctl.col = OW'(ad_ff);
               end
               default: begin
                  ctl.tab = TB_INNER;
                  ctl.row = ad_ff;
                  ctl.col = OW'(da_ff);
               end
            endcase
            state_in = S_SUB;
         end
         S_SUB: begin
            ctl.sub = 1'b1;
            if (lvl_ff == 2'd2) begin
               state_in = S_DONE;
               st_in = 2'd1;
            end else begin
               lvl_in = lvl_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         default: begin
            if (st_ff == 2'd1) begin
               st_in = 2'd0;
               r_in.out_anc_anc = aa_ff;
               r_in.out_anc_der = ad_ff;
               r_in.out_der_anc = da_ff;
               r_in.out_der_der = dd4;
               r_in.only_first_anc = af - aa_ff - ad_ff;
               r_in.only_first_der = df - da_ff - dd4;
               r_in.only_second_anc = as_ - aa_ff - da_ff;
               r_in.only_second_der = ds - ad_ff - dd4;
               v_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
      endcase
      if (csr_write) ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         v_ff <= 1'b0;
         st_ff <= '0;
         total_ff <= '0;
         for (int k = 0; k < 4; k++) marg_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         v_ff <= v_in;
         st_ff <= st_in;
         total_ff <= total_in;
         if (csr_write) marg_ff[csr_index] <= (csr_data > 4'(MAX_COUNT)) ? 4'(MAX_COUNT) : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      i_ff <= i_in;
      j_ff <= j_in;
      lvl_ff <= lvl_in;
      aa_ff <= aa_in;
      ad_ff <= ad_in;
      da_ff <= da_in;
      r_ff <= r_in;
   end

   assign rsp_valid = v_ff;
   assign rsp_data = r_ff;

`ifndef SYNTHESIS
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back responses");
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> !rsp_valid) else $error("response while idle");
   a_ready_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NOT_BUILT) |-> !ready_ff)
      else $error("not built with tables ready");
`endif
endmodule
`default_nettype wire

FILE: src/two_locus_config_rank_unrank_top.sv
`default_nettype none
// Ranks and unranks two-locus configurations. Pulse start while busy is low with a
// command. Build fills the offset tables; rank and unrank walk them through one
// read port per table. The single result appears for one cycle on rsp_valid and
// must be taken then: the receiver cannot stall. Any csr write invalidates the
// tables; rebuild before ranking.
module two_locus_config_rank_unrank_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire tlcrk_pkg::req_type req_data,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [3:0]         csr_data,
   output logic                    rsp_valid,
   output tlcrk_pkg::rsp_type      rsp_data
);
   import tlcrk_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic [16:0] in_value, add_value;

   tlcrk_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .req_data, .csr_write, .csr_index, .csr_data,
      .ctl, .in_value, .add_value, .sts, .rsp_valid, .rsp_data
   );

   tlcrk_datapath u_dp (
      .clock, .ctl, .in_value, .add_value, .sts
   );
endmodule
`default_nettype wire
